// ----- sv/lzsd_pkg.sv -----
package lzsd_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 8192;
  localparam int unsigned BLOCK_SIZE_DEF  = 1048576;

  localparam int unsigned RUN_W  = 9;
  localparam int unsigned DIST_W = 13;
  localparam int unsigned SKIP_W = 3;

  typedef logic [7:0] byte_t;

  localparam byte_t            TOKEN_REF    = 8'h20;
  localparam byte_t            TOKEN_EXT    = 8'hE0;
  localparam logic [RUN_W-1:0] REF_LEN_BASE = 9'd2;
  localparam logic [RUN_W-1:0] EXT_LEN_BASE = 9'd9;
  localparam logic [SKIP_W-1:0] SKIP_BYTES  = 3'd4;

  typedef enum logic [4:0] {
    PH_TOKEN    = 5'b00001,
    PH_LITERAL  = 5'b00010,
    PH_LENGTH   = 5'b00100,
    PH_DISTANCE = 5'b01000,
    PH_COPY     = 5'b10000
  } phase_e;

  typedef struct packed {
    logic  emit;
    logic  copy;
    logic  consumed;
    logic  zero;
    byte_t lit;
  } item_ctl_t;

endpackage

// ----- sv/lzsd_if.sv -----
interface lzsd_in_if;
  logic            valid;
  logic            ready;
  lzsd_pkg::byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzsd_out_if;
  logic            valid;
  logic            ready;
  logic            out_valid;
  lzsd_pkg::byte_t out_byte;
  logic            byte_consumed;

  modport source (output valid, output out_valid, output out_byte, output byte_consumed,
                  input ready);
  modport sink   (input valid, input out_valid, input out_byte, input byte_consumed,
                  output ready);
endinterface

// ----- sv/lzsd_ram.sv -----
module lzsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lzsd_decoder.sv -----
module lzsd_decoder #(
  parameter int unsigned WINDOW_SIZE = 8192,
  parameter int unsigned BLOCK_SIZE  = 1048576
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  lzsd_pkg::byte_t                in_byte_i,
  output lzsd_pkg::item_ctl_t            ctl_o,
  output logic [$clog2(WINDOW_SIZE)-1:0] raddr_o,
  output logic [$clog2(WINDOW_SIZE)-1:0] waddr_o
);

  import lzsd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned PW = $clog2(BLOCK_SIZE);

  phase_e              phase_q, phase_d;
  logic [RUN_W-1:0]    run_q, run_d, run_dec;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic [SKIP_W-1:0]   skip_q, skip_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [AW-1:0]       wptr_q, wptr_d;
  logic                wrapped_q, wrapped_d;
  logic [AW:0]         rd_sum;
  logic [AW-1:0]       raddr;
  item_ctl_t           ctl;

  assign rd_sum = (AW+1)'(wptr_q) + (AW+1)'(WINDOW_SIZE - 1) - (AW+1)'(dist_q);
  assign raddr  = (rd_sum >= (AW+1)'(WINDOW_SIZE)) ?
                  AW'(rd_sum - (AW+1)'(WINDOW_SIZE)) : rd_sum[AW-1:0];
  assign run_dec = (run_q != '0) ? run_q - RUN_W'(1) : '0;

  always_comb begin
    phase_d      = phase_q;
    run_d        = run_q;
    dist_d       = dist_q;
    skip_d       = skip_q;
    ctl          = '0;
    ctl.consumed = 1'b1;
    case (phase_q)
      PH_TOKEN: begin
        if ((pos_q == '0) && (skip_q != SKIP_BYTES)) begin
          skip_d = skip_q + SKIP_W'(1);
        end else begin
          if (pos_q == '0) begin
            skip_d = '0;
          end
          if (in_byte_i < TOKEN_REF) begin
            run_d   = RUN_W'(in_byte_i);
            phase_d = PH_LITERAL;
          end else begin
            dist_d = {in_byte_i[4], in_byte_i[3:0], 8'h00};
            if (in_byte_i < TOKEN_EXT) begin
              run_d   = RUN_W'(in_byte_i[7:5]) + REF_LEN_BASE;
              phase_d = PH_DISTANCE;
            end else begin
              run_d   = EXT_LEN_BASE;
              phase_d = PH_LENGTH;
            end
          end
        end
      end
      PH_LITERAL: begin
        ctl.emit = 1'b1;
        ctl.lit  = in_byte_i;
        if (run_q != '0) begin
          run_d = run_dec;
        end else begin
          phase_d = PH_TOKEN;
        end
      end
      PH_LENGTH: begin
        run_d   = run_q + RUN_W'(in_byte_i);
        phase_d = PH_DISTANCE;
      end
      PH_DISTANCE: begin
        dist_d  = dist_q + DIST_W'(in_byte_i);
        phase_d = PH_COPY;
      end
      PH_COPY: begin
        ctl.emit     = 1'b1;
        ctl.copy     = 1'b1;
        ctl.consumed = 1'b0;
        ctl.zero     = !wrapped_q && (raddr >= wptr_q);
        run_d        = run_dec;
        if (run_dec == '0) begin
          dist_d  = '0;
          phase_d = PH_TOKEN;
        end
      end
      default: begin
        phase_d = PH_TOKEN;
      end
    endcase
  end

  always_comb begin
    wptr_d    = wptr_q;
    wrapped_d = wrapped_q;
    pos_d     = pos_q;
    if (ctl.emit) begin
      if (wptr_q == AW'(WINDOW_SIZE - 1)) begin
        wptr_d    = '0;
        wrapped_d = 1'b1;
      end else begin
        wptr_d = wptr_q + AW'(1);
      end
      pos_d = (pos_q == PW'(BLOCK_SIZE - 1)) ? '0 : pos_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TOKEN;
      run_q     <= '0;
      dist_q    <= '0;
      skip_q    <= '0;
      pos_q     <= '0;
      wptr_q    <= '0;
      wrapped_q <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      run_q     <= run_d;
      dist_q    <= dist_d;
      skip_q    <= skip_d;
      pos_q     <= pos_d;
      wptr_q    <= wptr_d;
      wrapped_q <= wrapped_d;
    end
  end

  assign ctl_o   = ctl;
  assign raddr_o = raddr;
  assign waddr_o = wptr_q;

endmodule

// ----- sv/lz77_stream_decompressor_unit.sv -----
// LZ77 stream decompressor. Every accepted input transaction yields exactly one output
// transaction, at a sustained rate of one per clock while the output is not stalled, through
// a history read stage, then an output register. The output history lives in one
// WINDOW_SIZE x 8 RAM: a copy step reads it when the transaction is accepted and the emitted
// byte is written back as the transaction leaves the read stage; a copy of the byte emitted
// just before is forwarded around the RAM. History never written since reset reads as zero
// by tracking the fill level, so no clearing pass runs and the block is ready right after reset.
module lz77_stream_decompressor_unit #(
  parameter int unsigned WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned BLOCK_SIZE  = lzsd_pkg::BLOCK_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lzsd_in_if.sink           in_i,
  lzsd_out_if.source        out_o
);

  import lzsd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_SIZE);

  item_ctl_t     ctl;
  logic [AW-1:0] raddr, waddr;
  logic          accept, s1_adv, fwd;
  byte_t         rdata, s1_byte;

  logic          s1_valid_q;
  item_ctl_t     s1_ctl_q;
  logic          s1_fwd_q;
  byte_t         s1_fwd_byte_q;
  logic [AW-1:0] s1_waddr_q;

  logic          out_valid_q;
  logic          out_flag_q;
  byte_t         out_byte_q;
  logic          out_consumed_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign accept      = in_i.valid && in_i.ready;
  assign fwd         = ctl.copy && s1_valid_q && s1_ctl_q.emit && (raddr == s1_waddr_q);

  lzsd_decoder #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .BLOCK_SIZE  (BLOCK_SIZE)
  ) u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .ctl_o     (ctl),
    .raddr_o   (raddr),
    .waddr_o   (waddr)
  );

  lzsd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (s1_adv && s1_ctl_q.emit),
    .waddr_i (s1_waddr_q),
    .wdata_i (s1_byte),
    .re_i    (accept && ctl.copy),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_byte = '0;
    if (s1_ctl_q.emit) begin
      if (!s1_ctl_q.copy) begin
        s1_byte = s1_ctl_q.lit;
      end else if (s1_fwd_q) begin
        s1_byte = s1_fwd_byte_q;
      end else if (!s1_ctl_q.zero) begin
        s1_byte = rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q      <= ctl;
      s1_fwd_q      <= fwd;
      s1_fwd_byte_q <= s1_byte;
      s1_waddr_q    <= waddr;
    end
    if (s1_adv) begin
      out_flag_q     <= s1_ctl_q.emit;
      out_byte_q     <= s1_byte;
      out_consumed_q <= s1_ctl_q.consumed;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_valid     = out_flag_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.byte_consumed = out_consumed_q;

  a_fwd_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ctl.copy && s1_valid_q && s1_ctl_q.emit && (raddr == s1_waddr_q) |=> s1_fwd_q)
    else $error("copy of in-flight history byte not forwarded");

  a_copy_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_consumed_q |-> out_flag_q)
    else $error("copy transaction without emitted byte");

  a_stage_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !s1_valid_q || s1_adv)
    else $error("read stage overrun");

endmodule

// ----- tb/tb_lz77_stream_decompressor_unit.sv -----
`timescale 1ns / 1ps

module tb_lz77_stream_decompressor_unit;
  import lzsd_pkg::*;

  localparam int unsigned RAND_ITEMS  = 363;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef struct packed {
    logic  emit;
    byte_t data;
    logic  used;
  } dec_result_t;

  typedef struct packed {
    byte_t       data;
    logic        typed;
    dec_result_t res;
  } dir_row_t;

  localparam dec_result_t NO_OUT   = '{1'b0, 8'h00, 1'b1};
  localparam dec_result_t ZERO_CPY = '{1'b1, 8'h00, 1'b0};

  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{8'h00, 1'b1, NO_OUT},
    '{8'hFF, 1'b1, NO_OUT},
    '{8'hA5, 1'b1, NO_OUT},
    '{8'h5A, 1'b1, NO_OUT},
    '{8'h00, 1'b1, NO_OUT},
    '{8'hFF, 1'b1, '{1'b1, 8'hFF, 1'b1}},
    '{8'h01, 1'b1, NO_OUT},
    '{8'h00, 1'b1, '{1'b1, 8'h00, 1'b1}},
    '{8'h80, 1'b1, '{1'b1, 8'h80, 1'b1}},
    '{8'h3F, 1'b1, NO_OUT},
    '{8'hFF, 1'b1, NO_OUT},
    '{8'hFF, 1'b1, ZERO_CPY},
    '{8'h00, 1'b1, ZERO_CPY},
    '{8'hC3, 1'b1, ZERO_CPY},
    '{8'hE0, 1'b1, NO_OUT},
    '{8'h00, 1'b1, NO_OUT},
    '{8'h05, 1'b1, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT}
  };

  logic clk_i;
  logic rst_ni;

  lzsd_in_if  in_if ();
  lzsd_out_if out_if ();

  lz77_stream_decompressor_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  phase_e             dec_phase;
  logic [RUN_W-1:0]   run_len;
  logic [DIST_W-1:0]  back_dist;
  logic [SKIP_W-1:0]  skip_cnt;
  int unsigned        out_pos;
  logic [DIST_W-1:0]  wr_pos;
  byte_t              history [WINDOW_SIZE_DEF];

  dec_result_t decoded_q [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  logic        row_typed;
  dec_result_t row_res;

  function automatic void reset_decoder();
    dec_phase = PH_TOKEN;
    run_len   = '0;
    back_dist = '0;
    skip_cnt  = '0;
    out_pos   = 0;
    wr_pos    = '0;
    for (int i = 0; i < WINDOW_SIZE_DEF; i++) history[i] = 8'h00;
  endfunction

  function automatic byte_t emit_byte(input byte_t b);
    history[wr_pos] = b;
    wr_pos  = wr_pos + 1'b1;
    out_pos = (out_pos + 1) % BLOCK_SIZE_DEF;
    return b;
  endfunction

  function automatic dec_result_t decode_step(input byte_t b);
    dec_result_t       r;
    logic [DIST_W-1:0] rd;
    r = NO_OUT;
    case (dec_phase)
      PH_TOKEN: begin
        if (out_pos == 0 && skip_cnt != SKIP_BYTES) begin
          skip_cnt = skip_cnt + 1'b1;
        end else begin
          if (out_pos == 0) skip_cnt = '0;
          if (b < TOKEN_REF) begin
            run_len   = {1'b0, b};
            dec_phase = PH_LITERAL;
          end else if (b < TOKEN_EXT) begin
            back_dist = {b[4], b[3:0], 8'h00};
            run_len   = REF_LEN_BASE + RUN_W'(b[7:5]);
            dec_phase = PH_DISTANCE;
          end else begin
            back_dist = {b[4], b[3:0], 8'h00};
            run_len   = EXT_LEN_BASE;
            dec_phase = PH_LENGTH;
          end
        end
      end
      PH_LITERAL: begin
        r.emit = 1'b1;
        r.data = emit_byte(b);
        if (run_len > 0) run_len = run_len - 1'b1;
        else dec_phase = PH_TOKEN;
      end
      PH_LENGTH: begin
        run_len   = run_len + RUN_W'(b);
        dec_phase = PH_DISTANCE;
      end
      PH_DISTANCE: begin
        back_dist = back_dist + DIST_W'(b);
        dec_phase = PH_COPY;
      end
      default: begin
        rd     = wr_pos - 1'b1 - back_dist;
        r.used = 1'b0;
        r.emit = 1'b1;
        r.data = emit_byte(history[rd]);
        if (run_len > 0) run_len = run_len - 1'b1;
        if (run_len == 0) begin
          back_dist = '0;
          dec_phase = PH_TOKEN;
        end
      end
    endcase
    return r;
  endfunction

  // favor short runs and recent distances so copies replay real history
  function automatic byte_t pick_byte();
    byte_t       b;
    int unsigned sel;
    b   = byte_t'($urandom);
    sel = $urandom_range(99);
    if (dec_phase == PH_TOKEN && !(out_pos == 0 && skip_cnt != SKIP_BYTES)) begin
      if (sel < 40) begin
        b = byte_t'($urandom_range(sel < 10 ? 31 : 7));
      end else if (sel < 75) begin
        b = byte_t'($urandom_range(8'hDF, 8'h20));
        if (sel < 60) b[4:0] = '0;
      end else begin
        b = byte_t'($urandom_range(8'hFF, 8'hE0));
        if (sel < 90) b = TOKEN_EXT;
      end
    end else if (dec_phase == PH_LENGTH && sel < 90) begin
      b = byte_t'($urandom_range(15));
    end
    return b;
  endfunction

  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid   = 1'b0;
      in_if.in_byte = byte_t'($urandom);
      @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.in_byte = b;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("lz77_stream_decompressor_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    dec_result_t r;
    dec_result_t exp_r;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        r = decode_step(in_if.in_byte);
        decoded_q.push_back(row_typed ? row_res : r);
      end
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected transaction out_valid %b out_byte %h byte_consumed %b",
                   $time, out_if.out_valid, out_if.out_byte, out_if.byte_consumed);
          err_cnt++;
        end else begin
          exp_r = decoded_q.pop_front();
          if (out_if.out_valid !== exp_r.emit) begin
            $display("%0t: out_valid expected %b actual %b",
                     $time, exp_r.emit, out_if.out_valid);
            err_cnt++;
          end
          if (out_if.out_byte !== exp_r.data) begin
            $display("%0t: out_byte expected %h actual %h",
                     $time, exp_r.data, out_if.out_byte);
            err_cnt++;
          end
          if (out_if.byte_consumed !== exp_r.used) begin
            $display("%0t: byte_consumed expected %b actual %b",
                     $time, exp_r.used, out_if.byte_consumed);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned src_pct [4];
    int unsigned snk_pct [4];
    src_pct = '{0, 70, 0, 33};
    snk_pct = '{0, 0, 70, 33};
    err_cnt       = 0;
    cycle_cnt     = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    row_typed     = 1'b0;
    row_res       = NO_OUT;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    reset_decoder();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row_typed = DIRECTED_ROWS[i].typed;
      row_res   = DIRECTED_ROWS[i].res;
      send_byte(DIRECTED_ROWS[i].data);
    end
    row_typed = 1'b0;

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = src_pct[p];
      snk_stall_pct = snk_pct[p];
      repeat (RAND_ITEMS) send_byte(pick_byte());
    end

    in_if.valid   = 1'b0;
    snk_stall_pct = 0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("lz77_stream_decompressor_unit test passed");
    end else begin
      $display("lz77_stream_decompressor_unit test failed");
    end
    $finish;
  end

endmodule
